FILE: src/itp_pkg.sv
// Shared types, codes and character helpers for the infix-to-postfix converter.
package itp_pkg;

    // Default operator stack depth.
    localparam int STACK_DEPTH_DEF = 16;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes.
    localparam logic ERR_PAREN    = 1'b0;
    localparam logic ERR_OVERFLOW = 1'b1;

    // Item function codes.
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Characters with a special meaning.
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UC_LO  = 8'h41;
    localparam logic [7:0] CH_UC_HI  = 8'h5A;
    localparam logic [7:0] CH_LC_LO  = 8'h61;
    localparam logic [7:0] CH_LC_HI  = 8'h7A;

    // Command from the sequencer to the operator stack.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] wdata;
    } stk_cmd_t;

    // Operator precedence; every unlisted character ranks lowest.
    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_CARET) begin
            p = 2'd3;
        end
        else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
            p = 2'd2;
        end
        else if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end
        return p;
    endfunction

    // Letters and digits pass straight through.
    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= CH_DIG_LO && c <= CH_DIG_HI) ||
               (c >= CH_UC_LO && c <= CH_UC_HI) ||
               (c >= CH_LC_LO && c <= CH_LC_HI);
    endfunction

endpackage

FILE: src/itp_stack.sv
// Operator stack: entry memory, fill count and registered top-of-stack read.
module itp_stack #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  itp_pkg::stk_cmd_t                  cmd,
    output logic [$clog2(STACK_DEPTH+1)-1:0]   count,
    output logic [7:0]                         top_char,
    output logic                               full
);
    import itp_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    logic [7:0]       stack_mem_reg [STACK_DEPTH];
    logic [7:0]       top_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] top_pos;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;

    // The top entry sits one below the fill count.
    assign top_pos = count_reg - CNT_W'(1);
    assign rd_idx  = top_pos[IDX_W-1:0];
    assign wr_idx  = count_reg[IDX_W-1:0];

    // Fill count update; a clear wins over push and pop.
    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Entry memory: one write port, top entry read every cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem_reg[wr_idx] <= cmd.wdata;
        end
        top_reg <= stack_mem_reg[rd_idx];
    end

    assign count    = count_reg;
    assign top_char = top_reg;
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));

endmodule

FILE: src/infix_to_postfix_converter_top.sv
// Top level of the infix-to-postfix converter: item sequencer and result registers.
//
// Input channel (in_valid, in_stall, func, ch): one infix character per item, or an
// end-of-expression marker when func is set. in_stall is low only while the block
// waits for a new item, so one item is in work at a time.
// Output channel (out_valid, out_stall, kind, out_char, err_code, last): postfix
// characters, a completion result at the end marker, or an error result. last marks
// the final result of each item.
// Sequence: an accepted item goes from idle through evaluate and flush back to idle.
// Each operator popped from the stack adds a pass through a wait state, in which the
// registered top-of-stack read follows the new count.
// Results pass through a one-entry holding register so the final one can be tagged
// with last, then through the output register.
// A stalled receiver freezes the sequencer once both result registers are full; the
// held result stays on the outputs until taken.
// Reset empties the stack, clears the discard flag and drops any pending result.
// After an error on a character item, characters are dropped until the next end
// marker, which gives no result.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [7:0] ch,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] out_char,
    output logic       err_code,
    output logic       last
);
    import itp_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             func_reg, func_next;
    logic [7:0]       ch_reg, ch_next;
    logic             discard_reg, discard_next;

    logic             pend_valid_reg, pend_valid_next;
    logic [1:0]       pend_kind_reg, pend_kind_next;
    logic [7:0]       pend_char_reg, pend_char_next;
    logic             pend_err_reg, pend_err_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_kind_reg;
    logic [7:0]       out_char_reg;
    logic             out_err_reg;
    logic             out_last_reg;
    logic             out_load;
    logic             out_load_last;

    stk_cmd_t         stk_cmd;
    logic [CNT_W-1:0] stk_count;
    logic [7:0]       stk_top;
    logic             stk_full;
    logic             stk_empty;
    logic             top_open;
    logic             top_wins;

    logic             out_free;
    logic             emit_ok;

    logic             act_emit;
    logic [1:0]       act_kind;
    logic [7:0]       act_char;
    logic             act_err;
    logic             act_pop;
    logic             act_push;
    logic             act_clear;
    logic             act_set_disc;
    logic             act_clr_disc;
    logic [1:0]       act_state;

    // Operator stack.
    itp_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (stk_cmd),
        .count    (stk_count),
        .top_char (stk_top),
        .full     (stk_full)
    );

    // Stack status and the precedence compare.
    assign stk_empty = (stk_count == '0);
    assign top_open  = (stk_top == CH_LPAREN);
    assign top_wins  = (prec_of(stk_top) >= prec_of(ch_reg));

    // A new result can enter the holding register when it is empty or can move on.
    assign out_free = !out_valid_reg || !out_stall;
    assign emit_ok  = !pend_valid_reg || out_free;

    // Decision for the current item from its character and the stack top.
    always_comb
    begin
        act_emit     = 1'b0;
        act_kind     = KIND_CHAR;
        act_char     = '0;
        act_err      = ERR_PAREN;
        act_pop      = 1'b0;
        act_push     = 1'b0;
        act_clear    = 1'b0;
        act_set_disc = 1'b0;
        act_clr_disc = 1'b0;
        act_state    = S_FLUSH;
        if (func_reg == FUNC_END)
        begin
            priority if (discard_reg)
            begin
                act_clr_disc = 1'b1;
            end
            else if (!stk_empty && top_open)
            begin
                act_emit  = 1'b1;
                act_kind  = KIND_ERR;
                act_err   = ERR_PAREN;
                act_clear = 1'b1;
            end
            else if (!stk_empty)
            begin
                act_emit  = 1'b1;
                act_char  = stk_top;
                act_pop   = 1'b1;
                act_state = S_WAIT;
            end
            else
            begin
                act_emit = 1'b1;
                act_kind = KIND_DONE;
            end
        end
        else
        begin
            priority if (discard_reg)
            begin
                act_emit = 1'b0;
            end
            else if (is_alnum(ch_reg))
            begin
                act_emit = 1'b1;
                act_char = ch_reg;
            end
            else if (ch_reg == CH_RPAREN)
            begin
                priority if (!stk_empty && !top_open)
                begin
                    act_emit  = 1'b1;
                    act_char  = stk_top;
                    act_pop   = 1'b1;
                    act_state = S_WAIT;
                end
                else if (!stk_empty)
                begin
                    act_pop = 1'b1;
                end
                else
                begin
                    act_emit     = 1'b1;
                    act_kind     = KIND_ERR;
                    act_err      = ERR_PAREN;
                    act_set_disc = 1'b1;
                end
            end
            else if (ch_reg != CH_LPAREN && !stk_empty && !top_open && top_wins)
            begin
                act_emit  = 1'b1;
                act_char  = stk_top;
                act_pop   = 1'b1;
                act_state = S_WAIT;
            end
            else if (stk_full)
            begin
                act_emit     = 1'b1;
                act_kind     = KIND_ERR;
                act_err      = ERR_OVERFLOW;
                act_clear    = 1'b1;
                act_set_disc = 1'b1;
            end
            else
            begin
                act_push = 1'b1;
            end
        end
    end

    // Sequencer: one stack step per pass through the evaluate state.
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        ch_next         = ch_reg;
        discard_next    = discard_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_char_next  = pend_char_reg;
        pend_err_next   = pend_err_reg;
        out_load        = 1'b0;
        out_load_last   = 1'b0;
        stk_cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    ch_next    = ch;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!act_emit || emit_ok)
                begin
                    stk_cmd.push  = act_push;
                    stk_cmd.pop   = act_pop;
                    stk_cmd.clear = act_clear;
                    stk_cmd.wdata = ch_reg;
                    if (act_set_disc)
                    begin
                        discard_next = 1'b1;
                    end
                    if (act_clr_disc)
                    begin
                        discard_next = 1'b0;
                    end
                    if (act_emit)
                    begin
                        out_load        = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_kind_next  = act_kind;
                        pend_char_next  = act_char;
                        pend_err_next   = (act_kind == KIND_ERR) ? act_err : 1'b0;
                    end
                    state_next = act_state;
                end
            end
            S_WAIT:
            begin
                state_next = S_EVAL;
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_load_last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid: loaded from the holding register, cleared when taken.
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            discard_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            discard_reg    <= discard_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        ch_reg        <= ch_next;
        pend_kind_reg <= pend_kind_next;
        pend_char_reg <= pend_char_next;
        pend_err_reg  <= pend_err_next;
        if (out_load)
        begin
            out_kind_reg <= pend_kind_reg;
            out_char_reg <= pend_char_reg;
            out_err_reg  <= pend_err_reg;
            out_last_reg <= out_load_last;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign out_char  = out_char_reg;
    assign err_code  = out_err_reg;
    assign last      = out_last_reg;

    // A new item is taken only with no result left over from the previous one.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !pend_valid_reg)
        else $error("item accepted with a pending result");

    // The stack never holds more entries than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // While input is discarded after an error the stack stays empty.
    a_discard_empty: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> (stk_count == '0))
        else $error("stack not empty while discarding");

    // The read wait state after a pop is always followed by a new evaluation.
    a_wait_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |=> (state_reg == S_EVAL))
        else $error("read wait not followed by evaluation");

endmodule

FILE: sim/infix_to_postfix_converter_top_tb.sv
// Self-checking testbench for the infix-to-postfix converter: directed table, random expressions, idling phases.
module infix_to_postfix_converter_top_tb;
    import itp_pkg::*;

    localparam int STACK_DEPTH    = STACK_DEPTH_DEF;
    localparam int RAND_ITEMS     = 500;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 60;
    localparam int DIR_ROWS       = 25;

    // One postfix result as it leaves the block.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_char;
        logic       err_code;
        logic       last;
    } postfix_res_t;

    // One input item.
    typedef struct packed {
        logic       f;
        logic [7:0] c;
    } infix_item_t;

    // Directed row: the item, how often it repeats, and an optional typed-in result.
    typedef struct packed {
        logic       f;
        logic [7:0] c;
        logic [4:0] reps;
        logic       fixed;
        logic [1:0] kind;
        logic [7:0] out_char;
        logic       err_code;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // Empty expression completes at once; extremes of the operand ranges.
        '{FUNC_END,  8'h00,     5'd1,  1'b1, KIND_DONE, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_DIG_LO, 5'd1,  1'b1, KIND_CHAR, CH_DIG_LO, ERR_PAREN},
        '{FUNC_CHAR, CH_LC_HI,  5'd1,  1'b1, KIND_CHAR, CH_LC_HI,  ERR_PAREN},
        // Unmatched closing parenthesis, then dropped items up to the end marker.
        '{FUNC_CHAR, CH_RPAREN, 5'd1,  1'b1, KIND_ERR,  8'h00,     ERR_PAREN},
        '{FUNC_CHAR, "q",       5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_END,  8'hFF,     5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        // NUL and 0xFF are lowest-rank operators; then every operator under a parenthesis.
        '{FUNC_CHAR, 8'h00,     5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, 8'hFF,     5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_LPAREN, 5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_CARET,  5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_CARET,  5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_STAR,   5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_PCT,    5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_SLASH,  5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_PLUS,   5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_MINUS,  5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_RPAREN, 5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_END,  8'h00,     5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        // Fill the stack with opening parentheses; one more push overflows.
        '{FUNC_CHAR, CH_LPAREN, 5'd16, 1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_LPAREN, 5'd1,  1'b1, KIND_ERR,  8'h00,     ERR_OVERFLOW},
        '{FUNC_END,  8'h00,     5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        // Opening parenthesis still open at the end marker.
        '{FUNC_CHAR, CH_LPAREN, 5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, "b",       5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_CHAR, CH_PLUS,   5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN},
        '{FUNC_END,  8'h00,     5'd1,  1'b0, KIND_CHAR, 8'h00,     ERR_PAREN}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       func;
    logic [7:0] ch;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_char;
    logic       err_code;
    logic       last;

    // Predictor state: operator stack, its depth and the drop-until-end flag.
    logic [7:0]   op_stk [STACK_DEPTH];
    int           stk_depth;
    bit           dropping;
    postfix_res_t fresh_q [$];
    postfix_res_t postfix_q [$];
    infix_item_t  seq_q [$];

    int fail_cnt       = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit hold_req       = 1'b0;
    bit hold_done      = 1'b0;
    int quiet_cycles   = 0;

    always #10 clk = ~clk;

    infix_to_postfix_converter_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .ch       (ch),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind     (kind),
        .out_char (out_char),
        .err_code (err_code),
        .last     (last)
    );

    // Letters and digits go straight to the output.
    function automatic bit is_operand(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic int op_rank(logic [7:0] c);
        case (c)
            CH_CARET:                  return 3;
            CH_STAR, CH_SLASH, CH_PCT: return 2;
            CH_PLUS, CH_MINUS:         return 1;
            default:                   return 0;
        endcase
    endfunction

    function automatic void emit(logic [1:0] k, logic [7:0] c, logic e);
        postfix_res_t r;
        r.kind     = k;
        r.out_char = c;
        r.err_code = e;
        r.last     = 1'b0;
        fresh_q.push_back(r);
    endfunction

    function automatic void pop_emit();
        emit(KIND_CHAR, op_stk[stk_depth - 1], 1'b0);
        stk_depth--;
    endfunction

    // A push onto a full stack ends the expression with an overflow error.
    function automatic void push_op(logic [7:0] c);
        if (stk_depth >= STACK_DEPTH) begin
            stk_depth = 0;
            dropping  = 1'b1;
            emit(KIND_ERR, 8'h00, ERR_OVERFLOW);
        end
        else begin
            op_stk[stk_depth] = c;
            stk_depth++;
        end
    endfunction

    // Works out the results of one item into fresh_q; returns 1 when the item is dropped.
    function automatic bit convert_item(logic f, logic [7:0] c);
        bit ignored;
        ignored = 1'b0;
        fresh_q.delete();
        if (f == FUNC_END) begin
            if (dropping) begin
                dropping = 1'b0;
                ignored  = 1'b1;
            end
            else begin
                while (stk_depth > 0 && op_stk[stk_depth - 1] != CH_LPAREN)
                    pop_emit();
                if (stk_depth > 0) begin
                    stk_depth = 0;
                    emit(KIND_ERR, 8'h00, ERR_PAREN);
                end
                else begin
                    emit(KIND_DONE, 8'h00, 1'b0);
                end
            end
        end
        else if (dropping) begin
            ignored = 1'b1;
        end
        else if (is_operand(c)) begin
            emit(KIND_CHAR, c, 1'b0);
        end
        else if (c == CH_LPAREN) begin
            push_op(c);
        end
        else if (c == CH_RPAREN) begin
            while (stk_depth > 0 && op_stk[stk_depth - 1] != CH_LPAREN)
                pop_emit();
            if (stk_depth > 0) begin
                stk_depth--;
            end
            else begin
                dropping = 1'b1;
                emit(KIND_ERR, 8'h00, ERR_PAREN);
            end
        end
        else begin
            // Pop down to a parenthesis or a lower-ranked operator.
            while (stk_depth > 0 && op_stk[stk_depth - 1] != CH_LPAREN &&
                   op_rank(op_stk[stk_depth - 1]) >= op_rank(c))
                pop_emit();
            push_op(c);
        end
        if (fresh_q.size() > 0)
            fresh_q[fresh_q.size() - 1].last = 1'b1;
        return ignored;
    endfunction

    function automatic void add_item(logic f, logic [7:0] c);
        infix_item_t it;
        it.f = f;
        it.c = c;
        seq_q.push_back(it);
    endfunction

    function automatic logic [7:0] rand_operand();
        case ($urandom_range(2))
            0:       return 8'(CH_DIG_LO + $urandom_range(9));
            1:       return 8'(CH_UC_LO + $urandom_range(25));
            default: return 8'(CH_LC_LO + $urandom_range(25));
        endcase
    endfunction

    // Mostly the six arithmetic operators, sometimes any other non-operand byte.
    function automatic logic [7:0] rand_operator();
        logic [7:0] c;
        case ($urandom_range(9))
            0:       c = CH_CARET;
            1:       c = CH_STAR;
            2:       c = CH_SLASH;
            3:       c = CH_PCT;
            4:       c = CH_PLUS;
            5, 6:    c = CH_MINUS;
            default: begin
                c = 8'($urandom_range(255));
                while (is_operand(c) || c == CH_LPAREN || c == CH_RPAREN)
                    c = 8'($urandom_range(255));
            end
        endcase
        return c;
    endfunction

    // Builds one random item sequence: mostly well-formed expressions, some broken ones.
    function automatic void build_sequence();
        int pick;
        int open_cnt;
        int n_terms;
        pick = $urandom_range(99);
        seq_q.delete();
        if (pick < 72) begin
            open_cnt = 0;
            n_terms  = $urandom_range(1, 6);
            for (int k = 0; k < n_terms; k++) begin
                while (open_cnt < 4 && $urandom_range(3) == 0) begin
                    add_item(FUNC_CHAR, CH_LPAREN);
                    open_cnt++;
                end
                add_item(FUNC_CHAR, rand_operand());
                while (open_cnt > 0 && $urandom_range(2) == 0) begin
                    add_item(FUNC_CHAR, CH_RPAREN);
                    open_cnt--;
                end
                if (k < n_terms - 1)
                    add_item(FUNC_CHAR, rand_operator());
            end
            while (open_cnt > 0) begin
                add_item(FUNC_CHAR, CH_RPAREN);
                open_cnt--;
            end
        end
        else if (pick < 82) begin
            // Raw bytes with a random function bit.
            repeat ($urandom_range(1, 8))
                add_item(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
        else if (pick < 88) begin
            // Deep nesting near the stack depth, which may run past it.
            repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3))
                add_item(FUNC_CHAR, CH_LPAREN);
            add_item(FUNC_CHAR, rand_operand());
            add_item(FUNC_CHAR, rand_operator());
        end
        else if (pick < 94) begin
            // Closing parenthesis with no partner.
            add_item(FUNC_CHAR, rand_operand());
            add_item(FUNC_CHAR, rand_operator());
            add_item(FUNC_CHAR, rand_operand());
            add_item(FUNC_CHAR, CH_RPAREN);
            add_item(FUNC_CHAR, rand_operand());
        end
        else begin
            // Opening parenthesis left open at the end.
            add_item(FUNC_CHAR, CH_LPAREN);
            add_item(FUNC_CHAR, rand_operand());
            add_item(FUNC_CHAR, rand_operator());
            add_item(FUNC_CHAR, rand_operand());
        end
        add_item(FUNC_END, 8'($urandom_range(255)));
    endfunction

    // Offers one item, waits for it to be taken and queues its expected results.
    task automatic offer_item(input logic f, input logic [7:0] c, input bit has_fixed,
                              input postfix_res_t fixed_res, output bit ignored);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        ch       <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ignored = convert_item(f, c);
        if (has_fixed)
            postfix_q.push_back(fixed_res);
        else
            foreach (fresh_q[i])
                postfix_q.push_back(fresh_q[i]);
    endtask

    // Receiver: one long hold on request, otherwise random stalls for the phase.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge clk) begin
        postfix_res_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (postfix_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, got kind=%0d char=%h err=%0d last=%0d",
                         $time, kind, out_char, err_code, last);
                fail_cnt++;
            end
            else begin
                want = postfix_q.pop_front();
                if (kind !== want.kind || out_char !== want.out_char ||
                    err_code !== want.err_code || last !== want.last) begin
                    $display("%0t: mismatch: expected kind=%0d char=%h err=%0d last=%0d, got kind=%0d char=%h err=%0d last=%0d",
                             $time, want.kind, want.out_char, want.err_code, want.last,
                             kind, out_char, err_code, last);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Reset, directed table, then random expressions through the idling phases.
    initial begin
        postfix_res_t fixed_res;
        bit           ignored;
        int           counted;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FUNC_CHAR;
        ch        = 8'h00;
        stk_depth = 0;
        dropping  = 1'b0;
        counted   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIR_ROWS; row++) begin
            fixed_res = {DIR_TAB[row].kind, DIR_TAB[row].out_char, DIR_TAB[row].err_code, 1'b1};
            for (int rep = 0; rep < DIR_TAB[row].reps; rep++)
                offer_item(DIR_TAB[row].f, DIR_TAB[row].c, DIR_TAB[row].fixed, fixed_res,
                           ignored);
        end

        while (counted < RAND_ITEMS) begin
            case (counted * 4 / RAND_ITEMS)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // Long receiver hold while the sender keeps offering.
                    if (counted >= 30)
                        hold_req = 1'b1;
                end
                1: begin
                    send_idle_pct  = 50;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 50;
                end
                default: begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase
            build_sequence();
            foreach (seq_q[i]) begin
                offer_item(seq_q[i].f, seq_q[i].c, 1'b0, '0, ignored);
                if (!ignored)
                    counted++;
            end
        end
        in_valid <= 1'b0;

        // Drain, then give stray results a chance to show up.
        while (postfix_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/itp_pkg.sv
src/itp_stack.sv
src/infix_to_postfix_converter_top.sv
sim/infix_to_postfix_converter_top_tb.sv
